FILE: hw/rtl/mgcd_pkg.sv
// Shared types and constants for the GOP closed-flag detector.
`timescale 1ns / 1ps

package mgcd_pkg;

   localparam int WIN_DEPTH = 10;

   localparam logic [7:0] PREFIX_ZERO = 8'h00;
   localparam logic [7:0] PREFIX_ONE  = 8'h01;
   localparam logic [7:0] GOP_CODE    = 8'hB8;
   localparam int         CLOSED_BIT  = 6;

   localparam logic [1:0] CODEC_ALWAYS_CLOSED = 2'd0;
   localparam logic [1:0] CODEC_MPEG2         = 2'd1;

   localparam logic [1:0] STATUS_NONE    = 2'd0;
   localparam logic [1:0] STATUS_OPEN    = 2'd1;
   localparam logic [1:0] STATUS_CLOSED  = 2'd2;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

   typedef struct packed {
      logic       occupied;
      logic [7:0] data;
   } cell_type;

endpackage

FILE: hw/rtl/mgcd_channels.sv
// Handshake interfaces for the byte input channel and the status result channel.
`timescale 1ns / 1ps

interface mgcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       last_byte;

   modport source(output valid, output packet_byte, output last_byte, input ready);
   modport sink(input valid, input packet_byte, input last_byte, output ready);
endinterface

interface mgcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] gop_status;

   modport source(output valid, output gop_status, input ready);
   modport sink(input valid, input gop_status, output ready);
endinterface

FILE: hw/rtl/mpeg2_gop_closed_detector_top.sv
// Top level of the GOP closed-flag detector: window cell chain and status scan.
`timescale 1ns / 1ps

// The detector takes one packet byte per item and returns one gop_status item on the
// byte marked last_byte. The ten-byte window is a chain of byte cells that shifts once
// per accepted item, and the eleven-byte start code compare is made in the same cycle.
// The status sits in an output register, so a new packet's bytes are accepted while the
// previous status waits; input is held off only when that register is full and not
// being taken. The codec class is written through the csr_ port, resets to the MPEG-2
// scan and must be written only between packets; the block does not enforce this.
module mpeg2_gop_closed_detector_top (
   input  logic       clock,
   input  logic       reset,
   mgcd_req_if.sink   req_chan,
   mgcd_rsp_if.source rsp_chan,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data
);

   mgcd_pkg::cell_type cells [mgcd_pkg::WIN_DEPTH];
   mgcd_pkg::cell_type feed  [mgcd_pkg::WIN_DEPTH];
   logic               accept;
   logic               ready;

   genvar i;
   generate
      for (i = 0; i < mgcd_pkg::WIN_DEPTH; i++) begin : g_cell
         if (i == mgcd_pkg::WIN_DEPTH - 1) begin : g_tail
            assign feed[i] = '{occupied: 1'b1, data: req_chan.packet_byte};
         end else begin : g_body
            assign feed[i] = cells[i + 1];
         end
         mgcd_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (accept),
            .clear     (req_chan.last_byte),
            .neighbour (feed[i]),
            .held      (cells[i])
         );
      end
   endgenerate

   mgcd_scan u_scan (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .cur_byte         (req_chan.packet_byte),
      .last_byte        (req_chan.last_byte),
      .window_cells     (cells),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_chan.ready),
      .req_ready        (ready),
      .accept           (accept),
      .rsp_valid        (rsp_chan.valid),
      .gop_status       (rsp_chan.gop_status)
   );

   assign req_chan.ready = ready;

endmodule

FILE: hw/rtl/mgcd_cell.sv
// One byte cell of the packet window shift chain.
`timescale 1ns / 1ps

module mgcd_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  logic              clear,
   input  mgcd_pkg::cell_type neighbour,
   output mgcd_pkg::cell_type held
);

   mgcd_pkg::cell_type held_ff;
   mgcd_pkg::cell_type held_in;

   always_comb begin
      held_in = held_ff;
      if (shift && clear) begin
         held_in = '0;
      end else if (shift) begin
         held_in = neighbour;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   assign held = held_ff;

endmodule

FILE: hw/rtl/mgcd_scan.sv
// Start code match, per-packet flags, codec class register and status output register.
`timescale 1ns / 1ps

module mgcd_scan (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [7:0]         cur_byte,
   input  logic               last_byte,
   input  mgcd_pkg::cell_type window_cells [mgcd_pkg::WIN_DEPTH],
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_write_data,
   input  logic               rsp_ready,
   output logic               req_ready,
   output logic               accept,
   output logic               rsp_valid,
   output logic [1:0]         gop_status
);

   logic [1:0] codec_ff;
   logic       match_found_ff;
   logic       match_found_in;
   logic       closed_flag_ff;
   logic       closed_flag_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [1:0] gop_status_ff;
   logic [1:0] gop_status_in;
   logic       hit;
   logic       found_now;
   logic       closed_now;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign hit = !match_found_ff && window_cells[0].occupied
      && window_cells[0].data == mgcd_pkg::PREFIX_ZERO
      && window_cells[1].data == mgcd_pkg::PREFIX_ZERO
      && window_cells[2].data == mgcd_pkg::PREFIX_ONE
      && window_cells[3].data == mgcd_pkg::GOP_CODE
      && window_cells[8].data == mgcd_pkg::PREFIX_ZERO
      && window_cells[9].data == mgcd_pkg::PREFIX_ZERO
      && cur_byte == mgcd_pkg::PREFIX_ONE;

   assign found_now  = match_found_ff || hit;
   assign closed_now = match_found_ff ? closed_flag_ff
                                      : window_cells[7].data[mgcd_pkg::CLOSED_BIT];

   always_comb begin
      match_found_in = match_found_ff;
      closed_flag_in = closed_flag_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      gop_status_in  = gop_status_ff;
      if (accept) begin
         if (last_byte) begin
            match_found_in = 1'b0;
            closed_flag_in = 1'b0;
            rsp_valid_in   = 1'b1;
            unique case (codec_ff)
               mgcd_pkg::CODEC_ALWAYS_CLOSED: gop_status_in = mgcd_pkg::STATUS_CLOSED;
               mgcd_pkg::CODEC_MPEG2: begin
                  if (!found_now) begin
                     gop_status_in = mgcd_pkg::STATUS_NONE;
                  end else if (closed_now) begin
                     gop_status_in = mgcd_pkg::STATUS_CLOSED;
                  end else begin
                     gop_status_in = mgcd_pkg::STATUS_OPEN;
                  end
               end
               default: gop_status_in = mgcd_pkg::STATUS_UNKNOWN;
            endcase
         end else if (hit) begin
            match_found_in = 1'b1;
            closed_flag_in = closed_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codec_ff       <= mgcd_pkg::CODEC_MPEG2;
         match_found_ff <= 1'b0;
         closed_flag_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            codec_ff <= csr_write_data;
         end
         match_found_ff <= match_found_in;
         closed_flag_ff <= closed_flag_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      gop_status_ff <= gop_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign gop_status = gop_status_ff;

`ifndef SYNTHESIS
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> rsp_valid_ff)
      else $error("No result followed the last byte of a packet.");

   a_packet_clears_flags: assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> !match_found_ff && !closed_flag_ff)
      else $error("Match flags survived the end of a packet.");

   a_always_closed: assert property (@(posedge clock) disable iff (reset)
      accept && last_byte && codec_ff == mgcd_pkg::CODEC_ALWAYS_CLOSED
      |=> gop_status_ff == mgcd_pkg::STATUS_CLOSED)
      else $error("An always-closed codec reported a status other than closed.");

   a_closed_needs_match: assert property (@(posedge clock) disable iff (reset)
      closed_flag_ff |-> match_found_ff)
      else $error("Closed flag is set without a recorded match.");
`endif

endmodule
